// ===== rtl/touch_button_press_qualifier_defines.svh =====
// Assertion macros for the touch button press qualifier.
// Needs clk and rst_n in the scope of each use.
`ifndef TOUCH_BUTTON_PRESS_QUALIFIER_DEFINES_SVH
`define TOUCH_BUTTON_PRESS_QUALIFIER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TBPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbpq assertion failed");
`define TBPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbpq assertion failed");
`else
`define TBPQ_ASSERT_NOW(lbl, ante, cons)
`define TBPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tbpq_pkg.sv =====
// Shared types and constants of the touch button press qualifier.
// No dependencies.
package tbpq_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_HIGHLIGHT = 2'd1;
  localparam logic [1:0] EV_ABORT     = 2'd2;
  localparam logic [1:0] EV_RELEASE   = 2'd3;

  localparam logic [1:0]  ROT_SWAPPED  = 2'd0;
  localparam int          PANEL_H      = 240;
  localparam logic [15:0] DWELL_RESET  = 16'd50;
  localparam logic [14:0] RECIP3       = 15'd21846;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_POST} state_t;
  typedef enum logic [1:0] {PH_AWAIT, PH_TIMING, PH_FEEDBACK} phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        touched;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic [31:0] now_ms;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [1:0]  rect_rotation;
    logic        has_action;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [3:0] button_index;
    logic       fire_action;
    logic       table_full;
  } out_item_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic        rotated;
    logic        action;
  } entry_t;

  // query travelling down the cell row
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [12:0] px;
    logic [11:0] py;
  } token_t;

endpackage

// ===== rtl/tbpq_in_if.sv =====
// Input channel of the touch button press qualifier.
// Depends on tbpq_pkg.
interface tbpq_in_if;
  logic                valid;
  logic                ready;
  tbpq_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tbpq_out_if.sv =====
// Result channel of the touch button press qualifier.
// Depends on tbpq_pkg.
interface tbpq_out_if;
  logic                valid;
  logic                ready;
  tbpq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tbpq_cell.sv =====
// One button cell: holds a rectangle and hit-tests the passing query.
// Depends on tbpq_pkg.
module tbpq_cell #(
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  tbpq_pkg::entry_t    wr_entry,
  input  logic                active,
  input  logic [IDX_W-1:0]    self_idx,
  input  tbpq_pkg::token_t    tok_in,
  input  logic [IDX_W-1:0]    idx_in,
  output tbpq_pkg::token_t    tok_out,
  output logic [IDX_W-1:0]    idx_out,
  output logic                act_out
);

  tbpq_pkg::entry_t   entry_r;
  tbpq_pkg::token_t   tok_r;
  logic [IDX_W-1:0]   idx_r;

  logic [16:0] x_end;
  logic [16:0] y_end;
  logic [17:0] rot_lo;
  logic [17:0] rot_hi;
  logic        dir_hit;
  logic        rot_hit;
  logic        hit;

  always_comb begin
    x_end   = {1'b0, entry_r.left} + {1'b0, entry_r.width};
    y_end   = {1'b0, entry_r.top} + {1'b0, entry_r.height};
    dir_hit = ({3'b0, tok_in.px} >= entry_r.left) && ({4'b0, tok_in.px} < x_end) &&
              ({4'b0, tok_in.py} >= entry_r.top) && ({5'b0, tok_in.py} < y_end);
    // swapped box: x over top..top+height, y over 240-(left+width)..240-left
    rot_lo  = {6'b0, tok_in.py} + {1'b0, x_end};
    rot_hi  = {6'b0, tok_in.py} + {2'b0, entry_r.left};
    rot_hit = ({3'b0, tok_in.px} >= entry_r.top) && ({4'b0, tok_in.px} < y_end) &&
              (rot_lo >= 18'(tbpq_pkg::PANEL_H)) && (rot_hi < 18'(tbpq_pkg::PANEL_H));
    hit     = active && (entry_r.rotated ? rot_hit : dir_hit);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
    end
    tok_r.px <= tok_in.px;
    tok_r.py <= tok_in.py;
    if (!tok_in.found && hit) begin
      tok_r.found <= 1'b1;
      idx_r       <= self_idx;
    end else begin
      tok_r.found <= tok_in.found;
      idx_r       <= idx_in;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;
  assign act_out = entry_r.action;

endmodule

// ===== rtl/touch_button_press_qualifier.sv =====
// Touch button press qualifier: a row of button cells plus the press controller.
// Depends on tbpq_pkg, tbpq_in_if, tbpq_out_if, tbpq_cell and the defines header.
//
// Usage:
//   in_chan carries items: cmd 0 touch sample, cmd 1 load a button rectangle,
//   cmd 2 clear the table. Every item yields exactly one result on out_chan.
//   cfg_we/cfg_wdata write dwell_ms; write only while the block is idle.
//   A load, clear or unused cmd has its result registered in res_r and then
//   in the output register. A sample walks the cell row, one cell per cycle,
//   and its result then passes through res_r into the output register.
//   Items are taken one at a time; a sample occupies the block until it has
//   walked the whole cell row, so the cell row length sets its occupancy.
//   A finished result sits in the output register; the next item is accepted
//   while it waits. If out_chan stays stalled, the following result waits
//   in the controller and in_chan.ready stays low until the register frees.
//   Reset: table empty, press machine awaiting touch, dwell_ms = 50. The
//   rectangle stores are not cleared; no clearing pass is needed.
`include "touch_button_press_qualifier_defines.svh"
module touch_button_press_qualifier #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  tbpq_in_if.sink      in_chan,
  tbpq_out_if.source   out_chan,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  tbpq_pkg::state_t     state_r, state_nxt;
  tbpq_pkg::phase_t     phase_r, phase_nxt;
  logic [IDX_W-1:0]     held_r, held_nxt;
  logic [31:0]          start_r, start_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [15:0]          dwell_r;
  logic                 touched_r;
  logic [31:0]          now_r;
  tbpq_pkg::out_item_t  res_r, res_nxt;
  tbpq_pkg::out_item_t  out_data_r;
  logic                 out_valid_r;
  tbpq_pkg::token_t     head_r;

  logic                 acc;
  logic                 in_ready;
  logic                 load_go;
  logic                 launch;
  logic                 out_load;
  logic [31:0]          limit;
  logic                 same;
  logic [3:0]           btn;
  logic [28:0]          prod_x;
  tbpq_pkg::entry_t     new_entry;

  tbpq_pkg::token_t     tok_o [MAX_ENTRIES];
  logic [IDX_W-1:0]     idx_o [MAX_ENTRIES];
  wire  [MAX_ENTRIES-1:0] act_vec;
  wire  [MAX_ENTRIES:0]   vld;
  logic                 tail_v;
  logic                 tail_found;
  logic [IDX_W-1:0]     tail_idx;

  assign acc = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  assign new_entry.left    = in_chan.data.rect_x;
  assign new_entry.top     = in_chan.data.rect_y;
  assign new_entry.width   = in_chan.data.rect_w;
  assign new_entry.height  = in_chan.data.rect_h;
  assign new_entry.rotated = (in_chan.data.rect_rotation == tbpq_pkg::ROT_SWAPPED);
  assign new_entry.action  = in_chan.data.has_action;

  // floor(4*tx/3) through the reciprocal, exact for 4*tx below 2^15
  assign prod_x = 29'({in_chan.data.touch_x, 2'b00}) * 29'(tbpq_pkg::RECIP3);

  assign vld[0] = head_r.valid;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    tbpq_pkg::token_t  tin;
    logic [IDX_W-1:0]  iin;
    if (i == 0) begin : g_head
      assign tin = head_r;
      assign iin = '0;
    end else begin : g_link
      assign tin = tok_o[i-1];
      assign iin = idx_o[i-1];
    end
    tbpq_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (load_go && (count_r == CNT_W'(i))),
      .wr_entry (new_entry),
      .active   (CNT_W'(i) < count_r),
      .self_idx (IDX_W'(i)),
      .tok_in   (tin),
      .idx_in   (iin),
      .tok_out  (tok_o[i]),
      .idx_out  (idx_o[i]),
      .act_out  (act_vec[i])
    );
    assign vld[i+1] = tok_o[i].valid;
  end

  assign tail_v     = tok_o[MAX_ENTRIES-1].valid;
  assign tail_found = tok_o[MAX_ENTRIES-1].found;
  assign tail_idx   = idx_o[MAX_ENTRIES-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbpq_pkg::ST_IDLE: begin
        if (acc) begin
          state_nxt = (in_chan.data.cmd == tbpq_pkg::CMD_SAMPLE) ?
                      tbpq_pkg::ST_SCAN : tbpq_pkg::ST_POST;
        end
      end
      tbpq_pkg::ST_SCAN: begin
        if (tail_v) begin
          state_nxt = tbpq_pkg::ST_POST;
        end
      end
      tbpq_pkg::ST_POST: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = tbpq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbpq_pkg::ST_IDLE;
    endcase
  end

  // outputs and press machine
  always_comb begin
    res_nxt   = res_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    start_nxt = start_r;
    count_nxt = count_r;
    load_go   = 1'b0;
    launch    = 1'b0;
    out_load  = 1'b0;
    in_ready  = 1'b0;
    limit     = start_r + {16'b0, dwell_r};
    same      = tail_found && (tail_idx == held_r);
    btn       = 4'(held_r);
    unique case (state_r)
      tbpq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          res_nxt = '0;
          unique case (in_chan.data.cmd)
            tbpq_pkg::CMD_LOAD: begin
              if (count_r < CNT_W'(MAX_ENTRIES)) begin
                load_go   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                res_nxt.table_full = 1'b1;
              end
            end
            tbpq_pkg::CMD_CLEAR:  count_nxt = '0;
            tbpq_pkg::CMD_SAMPLE: launch = 1'b1;
            default: ;
          endcase
        end
      end
      tbpq_pkg::ST_SCAN: begin
        if (tail_v) begin
          res_nxt = '0;
          if (touched_r) begin
            unique case (phase_r)
              tbpq_pkg::PH_AWAIT: begin
                if (tail_found) begin
                  held_nxt  = tail_idx;
                  start_nxt = now_r;
                  phase_nxt = tbpq_pkg::PH_TIMING;
                end
              end
              tbpq_pkg::PH_TIMING: begin
                if (now_r > limit) begin
                  if (!same) begin
                    phase_nxt = tbpq_pkg::PH_AWAIT;
                  end else begin
                    phase_nxt            = tbpq_pkg::PH_FEEDBACK;
                    res_nxt.event_res    = tbpq_pkg::EV_HIGHLIGHT;
                    res_nxt.button_index = btn;
                  end
                end
              end
              tbpq_pkg::PH_FEEDBACK: begin
                if (!same) begin
                  phase_nxt            = tbpq_pkg::PH_AWAIT;
                  res_nxt.event_res    = tbpq_pkg::EV_ABORT;
                  res_nxt.button_index = btn;
                end
              end
              default: phase_nxt = tbpq_pkg::PH_AWAIT;
            endcase
          end else begin
            if (phase_r == tbpq_pkg::PH_FEEDBACK) begin
              res_nxt.event_res    = tbpq_pkg::EV_RELEASE;
              res_nxt.button_index = btn;
              res_nxt.fire_action  = act_vec[held_r];
            end
            phase_nxt = tbpq_pkg::PH_AWAIT;
          end
        end
      end
      tbpq_pkg::ST_POST: out_load = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tbpq_pkg::ST_IDLE;
      phase_r      <= tbpq_pkg::PH_AWAIT;
      held_r       <= '0;
      start_r      <= '0;
      count_r      <= '0;
      dwell_r      <= tbpq_pkg::DWELL_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      start_r      <= start_nxt;
      count_r      <= count_nxt;
      if (cfg_we) begin
        dwell_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else begin
      head_r.valid <= launch;
    end
    res_r <= res_nxt;
    if (acc) begin
      touched_r    <= in_chan.data.touched;
      now_r        <= in_chan.data.now_ms;
      head_r.found <= 1'b0;
      head_r.px    <= prod_x[28:16];
      head_r.py    <= 12'((14'(in_chan.data.touch_y) * 14'd3) >> 2);
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  `TBPQ_ASSERT_NOW(a_one_query, 1'b1, $countones(vld) <= 1)
  `TBPQ_ASSERT_NOW(a_tail_in_scan, tail_v, state_r == tbpq_pkg::ST_SCAN)
  `TBPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ENTRIES))
  `TBPQ_ASSERT_NOW(a_feedback_from_timing, (phase_r == tbpq_pkg::PH_FEEDBACK) && ($past(phase_r) != tbpq_pkg::PH_FEEDBACK), $past(phase_r) == tbpq_pkg::PH_TIMING)
  `TBPQ_ASSERT_NEXT(a_post_waits, (state_r == tbpq_pkg::ST_POST) && out_valid_r && !out_chan.ready, state_r == tbpq_pkg::ST_POST)

endmodule
